// File: rtl/cstu_pkg.sv
// Shared types and constants of the cycle segment interlacement test unit.
// No dependencies; imported by cstu_window and the top level.
`default_nettype none
package cstu_pkg;

    localparam int MAX_NODES = 64;
    localparam int NODE_W    = 6;
    localparam int ADDR_W    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int LABEL_W   = 7;
    localparam int HIT_DEPTH = 1 << LABEL_W;
    localparam int COUNT_W   = 7;
    localparam int SPAN_W    = COUNT_W + 1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_MARK  = 2'd1,
        OP_NODE  = 2'd2,
        OP_HIT   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN
    } state_t;

    typedef struct packed {
        op_t               operation;
        logic [NODE_W-1:0] node_index;
        logic              last;
    } in_item_t;

    typedef struct packed {
        logic conflict;
        logic bad_reference;
    } out_item_t;

    typedef struct packed {
        logic               clear;
        logic               set;
        logic [LABEL_W-1:0] label;
    } hit_ctrl_t;

endpackage
`default_nettype wire

// File: rtl/cstu_window.sv
// Label hit set and the window test for one candidate window per cycle.
// Depends on cstu_pkg.
`default_nettype none
module cstu_window (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire cstu_pkg::hit_ctrl_t        ctrl,
    input  wire logic [cstu_pkg::COUNT_W-1:0] window_index,
    input  wire logic [cstu_pkg::COUNT_W-1:0] ref_count,
    output logic                            holds
);
    import cstu_pkg::*;

    logic [HIT_DEPTH-1:0] hits_reg;
    logic [HIT_DEPTH-1:0] hits_next;
    logic [HIT_DEPTH-1:0] window_mask;
    logic [SPAN_W-1:0]    span;
    logic [SPAN_W-1:0]    k_lo;
    logic [SPAN_W-1:0]    k_mid;
    logic [SPAN_W-1:0]    k_up;
    logic [SPAN_W-1:0]    k_hi;

    always_comb
    begin
        hits_next = hits_reg;
        if (ctrl.set)
        begin
            hits_next[ctrl.label] = 1'b1;
        end
        // a clear comes after any pending hit
        if (ctrl.clear)
        begin
            hits_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hits_reg <= '0;
        end
        else
        begin
            hits_reg <= hits_next;
        end
    end

    // window {k, k+1, (k+2) mod 2n} with k = 2 * window_index
    always_comb
    begin
        span  = {ref_count, 1'b0};
        k_lo  = {window_index, 1'b0};
        k_mid = k_lo + SPAN_W'(1);
        k_up  = k_lo + SPAN_W'(2);
        k_hi  = (k_up == span) ? '0 : k_up;
        for (int i = 0; i < HIT_DEPTH; i++)
        begin
            window_mask[i] = (SPAN_W'(i) == k_lo) || (SPAN_W'(i) == k_mid)
                          || (SPAN_W'(i) == k_hi);
        end
    end

    assign holds = ~|(hits_reg & ~window_mask);

endmodule
`default_nettype wire

// File: rtl/cycle_segment_interlacement_test_unit.sv
// Top level of the cycle segment interlacement test unit.
// Depends on cstu_pkg and cstu_window.
//
// Items are taken when start is high and busy is low. Clear, mark, cycle-node
// and non-final hit items leave busy low, so they may be issued back to back.
// A hit item with last set raises busy: the load state waits for its label to
// come out of the registered label memory read, then the window scan tests one
// candidate window per cycle, stopping at the first window that holds all hits
// or after the last of the n windows for a reference with n attachments (no
// scan when the reference is bad). The result then appears on result for
// exactly one cycle with done high, in the same cycle busy drops; the receiver
// must take it then. The hit set is empty again after the result.
`default_nettype none
module cycle_segment_interlacement_test_unit (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire cstu_pkg::in_item_t   in_item,
    output logic                      busy,
    output logic                      done,
    output cstu_pkg::out_item_t       result
);
    import cstu_pkg::*;

    state_t             state_reg;
    state_t             state_next;
    logic [COUNT_W-1:0] ref_count_reg;
    logic [COUNT_W-1:0] ref_count_next;
    logic [COUNT_W-1:0] found_count_reg;
    logic [COUNT_W-1:0] found_count_next;
    logic [COUNT_W-1:0] window_reg;
    logic [COUNT_W-1:0] window_next;
    logic [MAX_NODES-1:0] mark_reg;
    logic [MAX_NODES-1:0] mark_next;
    logic               pend_reg;
    logic               pend_next;
    logic               done_reg;
    logic               done_next;
    out_item_t          result_reg;
    out_item_t          result_next;

    logic [LABEL_W-1:0] label_mem [MAX_NODES];
    logic [LABEL_W-1:0] rdata_reg;
    logic [LABEL_W-1:0] new_label;

    logic               accept;
    logic               in_range;
    logic [ADDR_W-1:0]  addr;
    logic               bad;
    logic               holds;
    logic               last_window;
    hit_ctrl_t          hit_ctrl;

    assign accept   = start && !busy;
    assign in_range = int'(in_item.node_index) < MAX_NODES;
    assign addr     = ADDR_W'(in_item.node_index);
    assign bad      = (ref_count_reg < COUNT_W'(2)) || (found_count_reg != ref_count_reg);
    assign last_window = (window_reg == ref_count_reg - COUNT_W'(1));

    // label of the next cycle node
    always_comb
    begin
        if (mark_reg[addr])
        begin
            new_label = {found_count_reg[COUNT_W-2:0], 1'b0};
        end
        else if (found_count_reg == '0)
        begin
            new_label = {ref_count_reg[COUNT_W-2:0], 1'b0} - LABEL_W'(1);
        end
        else
        begin
            new_label = {found_count_reg[COUNT_W-2:0], 1'b0} - LABEL_W'(1);
        end
    end

    // label memory: write on cycle nodes, read on hit items
    always_ff @(posedge clk)
    begin
        if (accept && in_range && in_item.operation == OP_NODE)
        begin
            label_mem[addr] <= new_label;
        end
        if (accept && in_item.operation == OP_HIT)
        begin
            rdata_reg <= label_mem[addr];
        end
    end

    // reference marks and counts
    always_comb
    begin
        mark_next        = mark_reg;
        ref_count_next   = ref_count_reg;
        found_count_next = found_count_reg;
        pend_next        = 1'b0;
        if (accept)
        begin
            case (in_item.operation)
                OP_CLEAR:
                begin
                    mark_next        = '0;
                    ref_count_next   = '0;
                    found_count_next = '0;
                end
                OP_MARK:
                begin
                    if (in_range && !mark_reg[addr])
                    begin
                        mark_next[addr] = 1'b1;
                        if (ref_count_reg != COUNT_MAX)
                        begin
                            ref_count_next = ref_count_reg + COUNT_W'(1);
                        end
                    end
                end
                OP_NODE:
                begin
                    if (in_range && mark_reg[addr] && found_count_reg != COUNT_MAX)
                    begin
                        found_count_next = found_count_reg + COUNT_W'(1);
                    end
                end
                OP_HIT:
                begin
                    pend_next = in_range;
                end
                default:
                begin
                    pend_next = 1'b0;
                end
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_item.operation == OP_HIT && in_item.last)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = bad ? ST_IDLE : ST_SCAN;
            end
            ST_SCAN:
            begin
                if (holds || last_window)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and hit control
    always_comb
    begin
        done_next      = 1'b0;
        result_next    = '0;
        window_next    = '0;
        hit_ctrl.set   = pend_reg;
        hit_ctrl.label = rdata_reg;
        hit_ctrl.clear = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                hit_ctrl.clear = accept && in_item.operation == OP_CLEAR;
            end
            ST_LOAD:
            begin
                if (bad)
                begin
                    done_next                 = 1'b1;
                    result_next.bad_reference = 1'b1;
                    hit_ctrl.clear            = 1'b1;
                end
            end
            ST_SCAN:
            begin
                if (holds)
                begin
                    done_next      = 1'b1;
                    hit_ctrl.clear = 1'b1;
                end
                else if (last_window)
                begin
                    done_next            = 1'b1;
                    result_next.conflict = 1'b1;
                    hit_ctrl.clear       = 1'b1;
                end
                else
                begin
                    window_next = window_reg + COUNT_W'(1);
                end
            end
            default:
            begin
                hit_ctrl.clear = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            mark_reg        <= '0;
            ref_count_reg   <= '0;
            found_count_reg <= '0;
            window_reg      <= '0;
            pend_reg        <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            mark_reg        <= mark_next;
            ref_count_reg   <= ref_count_next;
            found_count_reg <= found_count_next;
            window_reg      <= window_next;
            pend_reg        <= pend_next;
            done_reg        <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    cstu_window u_window (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (hit_ctrl),
        .window_index (window_reg),
        .ref_count    (ref_count_reg),
        .holds        (holds)
    );

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_item.operation == OP_HIT && in_item.last) |=> busy)
        else $error("final hit item did not start the test");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (window_reg < ref_count_reg))
        else $error("window index beyond reference span");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a test");

endmodule
`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 100ps
// Testbench for cycle_segment_interlacement_test_unit: directed and random items
// checked against a local interlacement predictor. Depends on cstu_pkg and the RTL.
module tb;
    import cstu_pkg::*;

    localparam int RANDOM_ITEMS = 1800;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int TAIL_CYCLES  = 80;
    localparam int ITEM_W       = $bits(in_item_t);

    typedef struct {
        in_item_t    item;
        int unsigned idle_pct;
        bit          drain;
    } pending_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    in_item_t  in_item = '0;
    logic      busy;
    logic      done;
    out_item_t result;

    cycle_segment_interlacement_test_unit u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .in_item (in_item),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    pending_t  stim_q[$];
    out_item_t verdict_q[$];
    logic      took_item = 1'b0;
    int        items_taken = 0;
    int        results_seen = 0;
    int        conflicts_seen = 0;
    int        bad_refs_seen = 0;
    int        error_count = 0;
    int        cycle_count = 0;

    // predictor state
    bit                 att_mark[MAX_NODES];
    logic [LABEL_W-1:0] node_label[MAX_NODES];
    logic [COUNT_W-1:0] ref_cnt;
    logic [COUNT_W-1:0] found_cnt;
    bit                 label_hit[HIT_DEPTH];

    // generator state
    bit          gen_written[MAX_NODES];
    int unsigned cur_idle = 0;
    bit          drain_next = 1'b0;
    int          queued_items = 0;

    function automatic bit window_covers_hits(int k, int span);
        for (int h = 0; h < HIT_DEPTH; h++)
        begin
            if (label_hit[h] && h != k && h != k + 1 && h != (k + 2) % span)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic bit segments_interlace();
        int span;
        span = 2 * int'(ref_cnt);
        for (int k = 0; k + 2 <= span; k += 2)
        begin
            if (window_covers_hits(k, span))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void predict_interlace(in_item_t it);
        int        idx;
        logic [7:0] wide;
        out_item_t verdict;
        idx = int'(it.node_index);
        case (it.operation)
            OP_CLEAR:
            begin
                foreach (att_mark[i]) att_mark[i] = 1'b0;
                foreach (label_hit[i]) label_hit[i] = 1'b0;
                ref_cnt   = '0;
                found_cnt = '0;
            end
            OP_MARK:
            begin
                if (idx < MAX_NODES && !att_mark[idx])
                begin
                    att_mark[idx] = 1'b1;
                    if (ref_cnt != COUNT_MAX)
                        ref_cnt++;
                end
            end
            OP_NODE:
            begin
                if (idx < MAX_NODES)
                begin
                    if (att_mark[idx])
                    begin
                        wide = {found_cnt, 1'b0};
                        node_label[idx] = wide[LABEL_W-1:0];
                        if (found_cnt != COUNT_MAX)
                            found_cnt++;
                    end
                    else
                    begin
                        // before the first attachment the node takes the wrap label
                        wide = (found_cnt == '0) ? {ref_cnt, 1'b0} - 8'd1
                                                 : {found_cnt, 1'b0} - 8'd1;
                        node_label[idx] = wide[LABEL_W-1:0];
                    end
                end
            end
            OP_HIT:
            begin
                if (idx < MAX_NODES)
                    label_hit[node_label[idx]] = 1'b1;
                if (it.last)
                begin
                    verdict.bad_reference = (ref_cnt < 2) || (found_cnt != ref_cnt);
                    verdict.conflict = !verdict.bad_reference && segments_interlace();
                    verdict_q.push_back(verdict);
                    foreach (label_hit[i]) label_hit[i] = 1'b0;
                end
            end
            default: ;
        endcase
    endfunction

    always @(negedge clk)
    begin : driver
        pending_t             nxt;
        logic [ITEM_W-1:0]    junk;
        if (rst_n && !(start && !took_item))
        begin
            if (stim_q.size() != 0 && !(stim_q[0].drain && verdict_q.size() != 0)
                && $urandom_range(99, 0) >= stim_q[0].idle_pct)
            begin
                nxt = stim_q.pop_front();
                start   <= 1'b1;
                in_item <= nxt.item;
            end
            else
            begin
                // idle: scramble the item, the block must ignore it
                junk = ITEM_W'($urandom);
                start   <= 1'b0;
                in_item <= in_item_t'(junk);
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        out_item_t want;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("FAILURE");
            $finish;
        end
        else if (rst_n)
        begin
            took_item <= start && !busy;
            if (done)
            begin
                results_seen++;
                conflicts_seen += int'(result.conflict);
                bad_refs_seen  += int'(result.bad_reference);
                if (verdict_q.size() == 0)
                begin
                    $error("result with nothing expected: conflict=%0b bad_reference=%0b",
                           result.conflict, result.bad_reference);
                    error_count++;
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (result.conflict !== want.conflict)
                    begin
                        $error("conflict: expected %0b, got %0b",
                               want.conflict, result.conflict);
                        error_count++;
                    end
                    if (result.bad_reference !== want.bad_reference)
                    begin
                        $error("bad_reference: expected %0b, got %0b",
                               want.bad_reference, result.bad_reference);
                        error_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                predict_interlace(in_item);
                items_taken++;
            end
        end
    end

    task automatic queue_item(op_t op, int idx, bit last);
        pending_t p;
        p.item.operation  = op;
        p.item.node_index = idx[NODE_W-1:0];
        p.item.last       = last;
        p.idle_pct        = cur_idle;
        p.drain           = drain_next;
        drain_next        = 1'b0;
        stim_q.push_back(p);
        if (op == OP_NODE)
            gen_written[idx] = 1'b1;
        queued_items++;
    endtask

    function automatic int pick_written();
        int idx;
        do
            idx = $urandom_range(MAX_NODES - 1, 0);
        while (!gen_written[idx]);
        return idx;
    endfunction

    // One reference build, a cycle walk and a few other segments. A broken round
    // drops the clear, skips or repeats an attachment, adds a late mark, or keeps
    // the reference down to a single attachment.
    task automatic queue_reference_round(bit broken);
        int order[MAX_NODES];
        bit is_att[MAX_NODES];
        int walk[$];
        int att_pos[$];
        int run[$];
        int att_n, cyc_n, segs, hit_n, j, tmp, flaw, s, p;
        bit skipped;
        for (int i = 0; i < MAX_NODES; i++)
        begin
            order[i]  = i;
            is_att[i] = 1'b0;
        end
        for (int i = MAX_NODES - 1; i > 0; i--)
        begin
            j = $urandom_range(i, 0);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        att_n = ($urandom_range(9, 0) == 0) ? $urandom_range(24, 7) : $urandom_range(6, 2);
        flaw  = broken ? $urandom_range(4, 0) : -1;
        if (flaw == 4)
            att_n = 1;
        cyc_n = att_n + (($urandom_range(3, 0) == 0) ? $urandom_range(30, 0)
                                                     : $urandom_range(5, 0));
        for (int i = 0; i < att_n; i++)
            is_att[order[i]] = 1'b1;

        if (flaw != 0)
            queue_item(OP_CLEAR, $urandom_range(63, 0), 1'($urandom_range(1, 0)));
        for (int i = 0; i < att_n; i++)
        begin
            queue_item(OP_MARK, order[i], 1'($urandom_range(1, 0)));
            if ($urandom_range(7, 0) == 0)
                queue_item(OP_MARK, order[i], 1'b0);
        end

        // shuffle the cycle part into walk order
        for (int i = cyc_n - 1; i > 0; i--)
        begin
            j = $urandom_range(i, 0);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        skipped = 1'b0;
        for (int i = 0; i < cyc_n; i++)
        begin
            if (flaw == 1 && is_att[order[i]] && !skipped)
                skipped = 1'b1;
            else
            begin
                queue_item(OP_NODE, order[i], 1'($urandom_range(1, 0)));
                walk.push_back(order[i]);
            end
        end
        if (walk.size() == 0)
            return;
        foreach (walk[i])
            if (is_att[walk[i]])
                att_pos.push_back(i);
        if (flaw == 2 && att_pos.size() != 0)
            queue_item(OP_NODE, walk[att_pos[0]], 1'b0);
        if (flaw == 3 && cyc_n < MAX_NODES)
            queue_item(OP_MARK, order[cyc_n], 1'b0);

        segs = $urandom_range(4, 1);
        for (int g = 0; g < segs; g++)
        begin
            hit_n = ($urandom_range(5, 0) == 0) ? $urandom_range(8, 5) : $urandom_range(4, 1);
            run.delete();
            if (att_pos.size() != 0 && $urandom_range(1, 0) == 1)
            begin
                // stay inside one attachment-arc-attachment stretch of the walk
                s = att_pos[$urandom_range(att_pos.size() - 1, 0)];
                p = s;
                run.push_back(walk[p]);
                do
                begin
                    p = (p + 1) % walk.size();
                    run.push_back(walk[p]);
                end
                while (!is_att[walk[p]]);
            end
            else
                run = walk;
            for (int h = 0; h < hit_n; h++)
                queue_item(OP_HIT, run[$urandom_range(run.size() - 1, 0)], h == hit_n - 1);
        end
    endtask

    // Walk two attachments far past the count so found_count saturates.
    task automatic queue_overrun_round();
        int a, b;
        a = $urandom_range(MAX_NODES - 1, 0);
        b = (a + $urandom_range(MAX_NODES - 1, 1)) % MAX_NODES;
        queue_item(OP_CLEAR, 0, 1'b0);
        queue_item(OP_MARK, a, 1'b0);
        queue_item(OP_MARK, b, 1'b0);
        for (int i = 0; i < 65; i++)
        begin
            queue_item(OP_NODE, a, 1'b0);
            queue_item(OP_NODE, b, 1'b0);
        end
        queue_item(OP_HIT, b, 1'b0);
        queue_item(OP_HIT, a, 1'b1);
    endtask

    initial
    begin : stimulus
        int unsigned idle_by_phase[4] = '{0, 55, 0, 32};
        int directed_n, round, phase, pick;

        // directed: three attachments 0, 63, 21 with arcs and a wrap node
        queue_item(OP_CLEAR, 0, 1'b0);
        queue_item(OP_MARK, 0, 1'b0);
        queue_item(OP_MARK, 63, 1'b0);
        queue_item(OP_MARK, 63, 1'b0);
        queue_item(OP_MARK, 21, 1'b1);
        queue_item(OP_NODE, 5, 1'b0);
        queue_item(OP_NODE, 0, 1'b0);
        queue_item(OP_NODE, 42, 1'b0);
        queue_item(OP_NODE, 63, 1'b0);
        queue_item(OP_NODE, 21, 1'b0);
        queue_item(OP_NODE, 37, 1'b0);
        queue_item(OP_HIT, 42, 1'b0);
        queue_item(OP_HIT, 63, 1'b1);
        queue_item(OP_HIT, 42, 1'b0);
        queue_item(OP_HIT, 37, 1'b1);
        drain_next = 1'b1;
        queue_item(OP_HIT, 0, 1'b1);
        // extra walk of an attachment: miscount
        queue_item(OP_NODE, 0, 1'b1);
        queue_item(OP_HIT, 5, 1'b1);
        // label written with no reference lands outside any window later
        queue_item(OP_CLEAR, 63, 1'b1);
        queue_item(OP_NODE, 50, 1'b0);
        queue_item(OP_MARK, 10, 1'b0);
        queue_item(OP_MARK, 11, 1'b0);
        queue_item(OP_NODE, 10, 1'b0);
        queue_item(OP_NODE, 11, 1'b0);
        queue_item(OP_HIT, 50, 1'b1);
        // empty reference
        queue_item(OP_CLEAR, 0, 1'b0);
        queue_item(OP_HIT, 50, 1'b1);
        directed_n = queued_items;

        round = 0;
        while (queued_items < directed_n + RANDOM_ITEMS)
        begin
            phase = (queued_items - directed_n) * 4 / RANDOM_ITEMS;
            cur_idle = idle_by_phase[(phase > 3) ? 3 : phase];
            drain_next = ($urandom_range(9, 0) == 0);
            pick = $urandom_range(99, 0);
            if (round == 3 || $urandom_range(79, 0) == 0)
                queue_overrun_round();
            else if (pick < 70)
                queue_reference_round(1'b0);
            else if (pick < 85)
                queue_reference_round(1'b1);
            else
            begin
                for (int i = $urandom_range(12, 3); i > 0; i--)
                begin
                    pick = $urandom_range(3, 0);
                    queue_item(op_t'(pick),
                               (op_t'(pick) == OP_HIT) ? pick_written()
                                                       : $urandom_range(63, 0),
                               $urandom_range(2, 0) == 0);
                end
            end
            round++;
        end

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        wait (items_taken == queued_items);
        wait (verdict_q.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Ran %0d items in %0d reference rounds, %0d results checked",
                 items_taken, round, results_seen);
        $display("  %0d conflicts and %0d bad references among them, sender gaps in phases",
                 conflicts_seen, bad_refs_seen);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: filelist.f
rtl/cstu_pkg.sv
rtl/cstu_window.sv
rtl/cycle_segment_interlacement_test_unit.sv
sim/tb.sv
